>>> rtl/bnc_pkg.sv
// bnc_pkg: shared widths, register indexes and transfer structs for box_neighbor_count
// no dependencies; used by every module under rtl except bnc_fifo

package bnc_pkg;

  localparam int unsigned MaxGrains = 64;   // default set size limit, range 2 to 64
  localparam int unsigned CoordW    = 24;   // centroid coordinate width, 8 fraction bits
  localparam int unsigned DiamW     = 24;   // diameter width, 8 fraction bits
  localparam int unsigned SumW      = 30;   // running diameter sum width
  localparam int unsigned NumW      = 7;    // grain numbers and counts, up to 64
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned JobDepth  = 2;
  localparam int unsigned ResDepth  = 4;

  localparam logic [CfgIdxW-1:0] CfgCollapseX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCollapseY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCollapseZ = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  // position write from the loader into the back end store
  typedef struct packed {
    logic            we;
    logic [NumW-1:0] addr;
    pos_t            pos;
  } wr_t;

  // one loaded set handed from front to back
  typedef struct packed {
    logic [NumW-1:0] n;
    logic [SumW-1:0] sum;
  } job_t;

  typedef struct packed {
    logic [NumW-1:0] grain;
    logic [NumW-1:0] count;
    logic            last;
  } res_t;

endpackage

>>> rtl/bnc_fifo.sv
// bnc_fifo: small register queue used for the job and result queues
// standalone, no package dependency

module bnc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/bnc_front.sv
// bnc_front: config registers, grain loader and diameter accumulator
// depends on bnc_pkg; feeds the store write port and the job queue

module bnc_front #(
  parameter int unsigned MAX_GRAINS = bnc_pkg::MaxGrains
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                         cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  bnc_pkg::coord_t              centroid_x_i,
  input  bnc_pkg::coord_t              centroid_y_i,
  input  bnc_pkg::coord_t              centroid_z_i,
  input  logic [bnc_pkg::DiamW-1:0]    diameter_i,
  input  logic                         last_grain_i,
  input  logic                         done_i,
  output bnc_pkg::wr_t                 wr_o,
  output logic                         job_push_o,
  output bnc_pkg::job_t                job_o
);

  logic                       collapse_x_q, collapse_y_q, collapse_z_q;
  logic [bnc_pkg::NumW-1:0]   count_q, count_d, n_next;
  logic [bnc_pkg::SumW-1:0]   sum_q, sum_d, sum_next;
  logic                       hold_q, hold_d;
  logic                       accept, room;

  // held off from the last grain of a set until the back end is done with it
  assign full_o = hold_q;
  assign accept = push_i && !hold_q;
  assign room   = (count_q < bnc_pkg::NumW'(MAX_GRAINS));

  assign n_next   = room ? count_q + 1'b1 : count_q;
  assign sum_next = room ? sum_q + bnc_pkg::SumW'(diameter_i) : sum_q;

  always_comb begin
    wr_o.we    = accept && room;
    wr_o.addr  = count_q;
    wr_o.pos.x = collapse_x_q ? '0 : centroid_x_i;
    wr_o.pos.y = collapse_y_q ? '0 : centroid_y_i;
    wr_o.pos.z = collapse_z_q ? '0 : centroid_z_i;
    job_o.n    = n_next;
    job_o.sum  = sum_next;
    job_push_o = 1'b0;
    count_d    = count_q;
    sum_d      = sum_q;
    hold_d     = hold_q;
    if (done_i) begin
      hold_d = 1'b0;
    end
    if (accept) begin
      if (last_grain_i) begin
        job_push_o = 1'b1;
        count_d    = '0;
        sum_d      = '0;
        hold_d     = 1'b1;
      end else begin
        count_d = n_next;
        sum_d   = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collapse_x_q <= 1'b0;
      collapse_y_q <= 1'b0;
      collapse_z_q <= 1'b0;
      count_q      <= '0;
      sum_q        <= '0;
      hold_q       <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bnc_pkg::CfgCollapseX: collapse_x_q <= cfg_data_i;
          bnc_pkg::CfgCollapseY: collapse_y_q <= cfg_data_i;
          bnc_pkg::CfgCollapseZ: collapse_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/bnc_back.sv
// bnc_back: position store, mean divider and pairwise box test sequencer
// depends on bnc_pkg; takes jobs from the job queue, pushes counts to the result queue

module bnc_back #(
  parameter int unsigned MAX_GRAINS = bnc_pkg::MaxGrains
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bnc_pkg::wr_t   wr_i,
  input  logic           job_empty_i,
  input  bnc_pkg::job_t  job_i,
  output logic           job_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output bnc_pkg::res_t  res_o,
  output logic           done_o
);

  localparam int unsigned AW    = $clog2(MAX_GRAINS);
  localparam int unsigned NW    = bnc_pkg::NumW;
  localparam int unsigned SW    = bnc_pkg::SumW;
  localparam int unsigned StepW = $clog2(bnc_pkg::SumW);
  localparam int unsigned DW    = bnc_pkg::CoordW + 1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv   = 6'b000010,
    StSpace = 6'b000100,
    StRun   = 6'b001000,
    StDrain = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  bnc_pkg::pos_t              mem_q [MAX_GRAINS];
  bnc_pkg::pos_t              rd_a_q, rd_b_q;

  state_e                     state_q, state_d;
  logic [NW-1:0]              n_q, n_d;
  logic [SW-1:0]              div_q, div_d;
  logic [SW-1:0]              quo_q, quo_d;
  logic [NW-1:0]              rem_q, rem_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [bnc_pkg::DiamW-1:0]  mean_q, mean_d;
  logic [NW-1:0]              i_q, i_d;
  logic [NW-1:0]              j_q, j_d;
  logic [NW-1:0]              cnt_q, cnt_d;
  logic                       p1_valid_q, p1_valid_d, p1_self_q, p1_self_d;
  logic                       p2_valid_q, p2_self_q;
  logic signed [DW-1:0]       diff_q [3];
  logic [DW-1:0]              mag [3];
  logic                       hit;

  logic [NW:0]                rem_sh, rem_nx;
  logic                       ge;
  logic [NW-1:0]              grain_no;
  logic                       row_last;

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_q, div_q[SW-1]};
  assign ge     = (rem_sh >= {1'b0, n_q});
  assign rem_nx = ge ? rem_sh - {1'b0, n_q} : rem_sh;

  // box test on the registered differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = diff_q[k][DW-1] ? DW'(-diff_q[k]) : DW'(diff_q[k]);
    end
  end
  assign hit = (mag[0] < {1'b0, mean_q}) && (mag[1] < {1'b0, mean_q}) &&
               (mag[2] < {1'b0, mean_q});

  assign grain_no = i_q + 1'b1;
  assign row_last = (grain_no == n_q);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    div_d      = div_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    step_d     = step_q;
    mean_d     = mean_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    p1_valid_d = 1'b0;
    p1_self_d  = 1'b0;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    done_o     = 1'b0;
    res_o.grain = grain_no;
    res_o.count = cnt_q + 1'b1;
    res_o.last  = row_last;

    if (p2_valid_q && !p2_self_q && hit) begin
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          n_d       = job_i.n;
          div_d     = job_i.sum;
          quo_d     = '0;
          rem_d     = '0;
          step_d    = '0;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        rem_d  = rem_nx[NW-1:0];
        quo_d  = {quo_q[SW-2:0], ge};
        div_d  = {div_q[SW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SW - 1)) begin
          mean_d  = quo_d[bnc_pkg::DiamW-1:0];
          i_d     = '0;
          cnt_d   = '0;
          state_d = StSpace;
        end
      end
      StSpace: begin
        // a row starts only with a free result slot
        if (!res_full_i) begin
          j_d     = '0;
          state_d = StRun;
        end
      end
      StRun: begin
        p1_valid_d = 1'b1;
        p1_self_d  = (j_q == i_q);
        j_d        = j_q + 1'b1;
        if (j_q == n_q - 1'b1) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        res_push_o = 1'b1;
        cnt_d      = '0;
        if (row_last) begin
          done_o  = 1'b1;
          state_d = StIdle;
        end else begin
          i_d     = grain_no;
          state_d = StSpace;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      n_q        <= '0;
      step_q     <= '0;
      mean_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      cnt_q      <= '0;
      p1_valid_q <= 1'b0;
      p1_self_q  <= 1'b0;
      p2_valid_q <= 1'b0;
      p2_self_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      step_q     <= step_d;
      mean_q     <= mean_d;
      i_q        <= i_d;
      j_q        <= j_d;
      cnt_q      <= cnt_d;
      p1_valid_q <= p1_valid_d;
      p1_self_q  <= p1_self_d;
      p2_valid_q <= p1_valid_q;
      p2_self_q  <= p1_self_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    diff_q[0] <= DW'(rd_a_q.x) - DW'(rd_b_q.x);
    diff_q[1] <= DW'(rd_a_q.y) - DW'(rd_b_q.y);
    diff_q[2] <= DW'(rd_a_q.z) - DW'(rd_b_q.z);
  end

  // position store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.pos;
    end
    rd_a_q <= mem_q[i_q[AW-1:0]];
    rd_b_q <= mem_q[j_q[AW-1:0]];
  end

endmodule

>>> rtl/box_neighbor_count.sv
// box_neighbor_count: top level, counts grains inside a mean-diameter box around each grain
// depends on bnc_pkg, bnc_fifo, bnc_front and bnc_back
// sequence: each set takes the job pop and the mean divide, then one row of pair tests per grain
//   at one pair test a cycle, each row waiting for a free result slot before it starts
// throughput: one grain a cycle while loading; full from the last grain until the final count
//   is queued; reset: asynchronous, clears config, counters, queues and sequencer, not the store

module box_neighbor_count #(
  parameter int unsigned MAX_GRAINS = bnc_pkg::MaxGrains
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [bnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                         cfg_data_i,
  // grain input handshake
  input  logic                         push,
  output logic                         full,
  input  bnc_pkg::coord_t              centroid_x_i,
  input  bnc_pkg::coord_t              centroid_y_i,
  input  bnc_pkg::coord_t              centroid_z_i,
  input  logic [bnc_pkg::DiamW-1:0]    diameter_i,
  input  logic                         last_grain_i,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output logic [bnc_pkg::NumW-1:0]     grain_number_o,
  output logic [bnc_pkg::NumW-1:0]     neighbor_count_o,
  output logic                         last_count_o
);

  bnc_pkg::wr_t   wr;
  bnc_pkg::job_t  job_in, job_out;
  bnc_pkg::res_t  res_in, res_out;
  logic           job_push, job_pop, job_full, job_empty;
  logic           res_push, res_full;
  logic           done;

  // front end: config, store writes and diameter sum
  bnc_front #(
    .MAX_GRAINS (MAX_GRAINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_o       (full),
    .centroid_x_i (centroid_x_i),
    .centroid_y_i (centroid_y_i),
    .centroid_z_i (centroid_z_i),
    .diameter_i   (diameter_i),
    .last_grain_i (last_grain_i),
    .done_i       (done),
    .wr_o         (wr),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  // finished sets wait here for the back end
  bnc_fifo #(
    .WIDTH ($bits(bnc_pkg::job_t)),
    .DEPTH (bnc_pkg::JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // back end: divide, pair tests, count per grain
  bnc_back #(
    .MAX_GRAINS (MAX_GRAINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .done_o      (done)
  );

  // result queue decouples the sequencer from the consumer's pop
  bnc_fifo #(
    .WIDTH ($bits(bnc_pkg::res_t)),
    .DEPTH (bnc_pkg::ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign grain_number_o   = res_out.grain;
  assign neighbor_count_o = res_out.count;
  assign last_count_o     = res_out.last;

  // a count is only produced into a free result slot
  a_res_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // one set at a time: a new set never lands on a pending job
  a_one_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (job_empty && !job_full))
    else $error("set handed over while another is pending");

  // the store is never written while counts are being produced
  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (full && !wr.we))
    else $error("input open while counts are produced");

  // every grain counts itself
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_in.count != '0))
    else $error("zero neighbor count");

endmodule

>>> tb/tb_box_neighbor_count.sv
// tb_box_neighbor_count: self-checking bench for box_neighbor_count, grain sets in, counts out
// depends on bnc_pkg and the box_neighbor_count rtl; a scoreboard class predicts each count

// predicts the neighbour count of every grain and holds the counts still owed by the block
class count_scoreboard;
  bit                           collapse_x;
  bit                           collapse_y;
  bit                           collapse_z;
  bnc_pkg::coord_t              pos_x[bnc_pkg::MaxGrains];
  bnc_pkg::coord_t              pos_y[bnc_pkg::MaxGrains];
  bnc_pkg::coord_t              pos_z[bnc_pkg::MaxGrains];
  logic [bnc_pkg::SumW-1:0]     diameter_sum;
  logic [bnc_pkg::DiamW-1:0]    mean_diameter;
  int unsigned                  loaded;
  bnc_pkg::res_t                expected_counts[$];
  int unsigned                  mismatches;

  function new();
    collapse_x    = 1'b0;
    collapse_y    = 1'b0;
    collapse_z    = 1'b0;
    diameter_sum  = '0;
    mean_diameter = '0;
    loaded        = 0;
    mismatches    = 0;
  endfunction

  function void set_collapse(logic [bnc_pkg::CfgIdxW-1:0] idx, bit val);
    case (idx)
      bnc_pkg::CfgCollapseX: collapse_x = val;
      bnc_pkg::CfgCollapseY: collapse_y = val;
      bnc_pkg::CfgCollapseZ: collapse_z = val;
      default: ;
    endcase
  endfunction

  // one grain transfer accepted; on the last grain the whole set of counts is predicted
  function void note_grain(bnc_pkg::coord_t x, bnc_pkg::coord_t y, bnc_pkg::coord_t z,
                           logic [bnc_pkg::DiamW-1:0] d, logic last);
    int unsigned              i;
    int unsigned              j;
    longint                   m;
    longint                   dx;
    longint                   dy;
    longint                   dz;
    logic [bnc_pkg::NumW-1:0] c;
    bnc_pkg::res_t            r;
    if (loaded < bnc_pkg::MaxGrains) begin
      pos_x[loaded] = collapse_x ? '0 : x;
      pos_y[loaded] = collapse_y ? '0 : y;
      pos_z[loaded] = collapse_z ? '0 : z;
      diameter_sum  = diameter_sum + d;
      loaded++;
    end
    if (!last || loaded == 0) return;
    mean_diameter = bnc_pkg::DiamW'(diameter_sum / loaded);
    m = longint'(mean_diameter);
    for (i = 0; i < loaded; i++) begin
      c = 1;
      for (j = 0; j < loaded; j++) begin
        if (j != i) begin
          dx = longint'(pos_x[i]) - longint'(pos_x[j]);
          dy = longint'(pos_y[i]) - longint'(pos_y[j]);
          dz = longint'(pos_z[i]) - longint'(pos_z[j]);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dz < 0) dz = -dz;
          if (dx < m && dy < m && dz < m) c++;
        end
      end
      r.grain = bnc_pkg::NumW'(i + 1);
      r.count = c;
      r.last  = (i + 1 == loaded);
      expected_counts = {expected_counts, r};
    end
    diameter_sum = '0;
    loaded       = 0;
  endfunction

  // one count transfer accepted from the block
  function void check_count(logic [bnc_pkg::NumW-1:0] g, logic [bnc_pkg::NumW-1:0] c,
                            logic l);
    bnc_pkg::res_t want;
    if (expected_counts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected count transfer: grain %0d count %0d last %0b",
                 $time, g, c, l);
      return;
    end
    want = expected_counts.pop_front();
    if (want.grain !== g || want.count !== c || want.last !== l) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: count mismatch: expected grain %0d count %0d last %0b, got %0d %0d %0b",
                 $time, want.grain, want.count, want.last, g, c, l);
    end
  endfunction

  function int pending();
    return expected_counts.size();
  endfunction
endclass

module tb_box_neighbor_count;

  localparam int unsigned StallLimit   = 20000;  // cycles with no transfer before giving up
  localparam int unsigned SettleCycles = 80;     // settling wait once every owed count has arrived
  localparam int unsigned HoldCycles   = 400;    // long receiver hold-off
  localparam int unsigned IdlePct      = 28;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_we_i         = 1'b0;
  logic [bnc_pkg::CfgIdxW-1:0]  cfg_idx_i        = bnc_pkg::CfgCollapseX;
  logic                         cfg_data_i       = 1'b0;
  logic                         push             = 1'b0;
  logic                         full;
  bnc_pkg::coord_t              centroid_x_i     = '0;
  bnc_pkg::coord_t              centroid_y_i     = '0;
  bnc_pkg::coord_t              centroid_z_i     = '0;
  logic [bnc_pkg::DiamW-1:0]    diameter_i       = '0;
  logic                         last_grain_i     = 1'b0;
  logic                         empty;
  logic                         pop              = 1'b0;
  logic [bnc_pkg::NumW-1:0]     grain_number_o;
  logic [bnc_pkg::NumW-1:0]     neighbor_count_o;
  logic                         last_count_o;

  count_scoreboard sb = new();

  // calm switches idling off on both sides; holds_asked asks the receiver for a long hold-off
  bit          calm        = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned idle_run    = 0;

  box_neighbor_count uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .centroid_x_i     (centroid_x_i),
    .centroid_y_i     (centroid_y_i),
    .centroid_z_i     (centroid_z_i),
    .diameter_i       (diameter_i),
    .last_grain_i     (last_grain_i),
    .empty            (empty),
    .pop              (pop),
    .grain_number_o   (grain_number_o),
    .neighbor_count_o (neighbor_count_o),
    .last_count_o     (last_count_o)
  );

  always #4 clk_i = ~clk_i;

  // receiver: random idling, or a long hold-off counted here while the sender keeps going
  always @(negedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left  = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // result monitor and watchdog, both sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_count(grain_number_o, neighbor_count_o, last_count_o);
    if ((push && !full) || (pop && !empty)) idle_run = 0;
    else idle_run++;
    if (idle_run >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("** box_neighbor_count: FAILED **");
      $finish;
    end
  end

  // offer one grain, idling first at random; returns at the edge where the transfer happens
  task automatic send_grain(bnc_pkg::coord_t x, bnc_pkg::coord_t y, bnc_pkg::coord_t z,
                            logic [bnc_pkg::DiamW-1:0] d, logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    centroid_x_i <= x;
    centroid_y_i <= y;
    centroid_z_i <= z;
    diameter_i   <= d;
    last_grain_i <= last;
    do @(posedge clk_i); while (full);
    sb.note_grain(x, y, z, d, last);
  endtask

  // sender stops and waits for every owed count, then lets the block settle
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bnc_pkg::CfgIdxW-1:0] idx, bit val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_collapse(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // new collapse setting, only ever with the block idle
  task automatic set_phase(bit cx, bit cy, bit cz);
    drain();
    write_reg(bnc_pkg::CfgCollapseX, cx);
    write_reg(bnc_pkg::CfgCollapseY, cy);
    write_reg(bnc_pkg::CfgCollapseZ, cz);
  endtask

  // one grain set: either scattered over the whole range or clustered round a random base
  task automatic send_random_set(int unsigned n);
    int unsigned               i;
    int unsigned               spread;
    bit                        wide;
    bnc_pkg::coord_t           bx;
    bnc_pkg::coord_t           by;
    bnc_pkg::coord_t           bz;
    bnc_pkg::coord_t           x;
    bnc_pkg::coord_t           y;
    bnc_pkg::coord_t           z;
    logic [bnc_pkg::DiamW-1:0] d;
    wide = ($urandom_range(3) == 0);
    case ($urandom_range(2))
      0:       spread = $urandom_range(16);
      1:       spread = $urandom_range(600);
      default: spread = $urandom_range(60000);
    endcase
    bx = bnc_pkg::coord_t'($urandom());
    by = bnc_pkg::coord_t'($urandom());
    bz = bnc_pkg::coord_t'($urandom());
    for (i = 0; i < n; i++) begin
      if (wide) begin
        x = bnc_pkg::coord_t'($urandom());
        y = bnc_pkg::coord_t'($urandom());
        z = bnc_pkg::coord_t'($urandom());
        d = bnc_pkg::DiamW'($urandom());
      end else begin
        // offsets wrap at the coordinate width, which is fine for the check
        x = bx + bnc_pkg::coord_t'($urandom_range(2 * spread)) - bnc_pkg::coord_t'(spread);
        y = by + bnc_pkg::coord_t'($urandom_range(2 * spread)) - bnc_pkg::coord_t'(spread);
        z = bz + bnc_pkg::coord_t'($urandom_range(2 * spread)) - bnc_pkg::coord_t'(spread);
        d = bnc_pkg::DiamW'($urandom_range(3 * spread + 1));
      end
      send_grain(x, y, z, d, i == n - 1);
    end
  endtask

  // mostly small sets, a few middling ones
  task automatic random_phase(int unsigned budget);
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(1, 6);
      else if (r < 90) n = $urandom_range(7, 12);
      else             n = $urandom_range(13, 24);
      if (n > budget - sent) n = budget - sent;
      send_random_set(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // lone grain at the coordinate extremes with the widest diameter
    send_grain(bnc_pkg::coord_t'(24'h7fffff), bnc_pkg::coord_t'(24'h800000), '0,
               24'hffffff, 1'b1);
    // zero mean: coincident grains still only count themselves
    send_grain(bnc_pkg::coord_t'(24'h001234), bnc_pkg::coord_t'(24'h001234),
               bnc_pkg::coord_t'(24'h001234), '0, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'h001234), bnc_pkg::coord_t'(24'h001234),
               bnc_pkg::coord_t'(24'h001234), '0, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'h001234), bnc_pkg::coord_t'(24'h001234),
               bnc_pkg::coord_t'(24'h001234), '0, 1'b1);
    // widest possible separation equals the mean, so not inside the box
    send_grain(bnc_pkg::coord_t'(24'h800000), '0, '0, 24'hffffff, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'h7fffff), '0, '0, 24'hffffff, 1'b1);
    // difference exactly on the mean, then one below it
    send_grain('0, '0, '0, 24'd256, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'd256), '0, '0, 24'd256, 1'b1);
    send_grain('0, '0, '0, 24'd256, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'd255), '0, '0, 24'd256, 1'b1);
    // a row of four with a truncated mean of 250
    send_grain('0, '0, '0, 24'd251, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'd100), '0, '0, 24'd250, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'd200), '0, '0, 24'd250, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'd300), '0, '0, 24'd250, 1'b1);
    // neighbours near the far corners of y and z
    send_grain(bnc_pkg::coord_t'(24'h7fffff), bnc_pkg::coord_t'(24'h7fffff),
               bnc_pkg::coord_t'(24'h800000), 24'hffffff, 1'b0);
    send_grain(bnc_pkg::coord_t'(24'h7fffff), bnc_pkg::coord_t'(24'h7ffffe),
               bnc_pkg::coord_t'(24'h800001), 24'hffffff, 1'b1);

    set_phase(1'b1, 1'b0, 1'b0);
    random_phase(35);
    set_phase(1'b0, 1'b1, 1'b1);
    random_phase(35);
    set_phase(1'b1, 1'b1, 1'b1);
    random_phase(35);

    // no idling on either side; a full set, then one too large whose tail is dropped
    set_phase(1'b0, 1'b0, 1'b0);
    calm = 1'b1;
    send_random_set(bnc_pkg::MaxGrains);
    send_random_set(bnc_pkg::MaxGrains + 3);
    random_phase(20);
    calm = 1'b0;

    // receiver holds off for a long stretch so the block fills and stalls its input
    set_phase(1'b0, 1'b1, 1'b0);
    holds_asked++;
    random_phase(35);
    set_phase(1'b0, 1'b0, 1'b1);
    random_phase(35);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** box_neighbor_count: PASSED **");
    else
      $display("** box_neighbor_count: FAILED **");
    $finish;
  end

endmodule
